@@ rtl/core/tskf_pkg.sv @@
package tskf_pkg;

    localparam int FRAC_BITS = 16;
    localparam int MUL_W     = 33;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int NUM_W     = 32 + FRAC_BITS;
    localparam int CNT_W     = $clog2(NUM_W);

    localparam logic [30:0] Q_RESET = 31'(64'd1 << (FRAC_BITS - 1));
    localparam logic [30:0] R_RESET = 31'(((64'd16 << FRAC_BITS) + 64'd50) / 64'd100);

    localparam logic signed [31:0] INT32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] INT32_MIN = 32'sh8000_0000;

    localparam logic OP_PREDICT = 1'b0;
    localparam logic OP_UPDATE  = 1'b1;

    localparam logic REG_ACCEL_NOISE = 1'b0;
    localparam logic REG_MEAS_VAR    = 1'b1;

    // predict program, one product per step
    localparam logic [3:0] PS_DT2  = 4'd0;
    localparam logic [3:0] PS_DT3  = 4'd1;
    localparam logic [3:0] PS_DT4  = 4'd2;
    localparam logic [3:0] PS_X0A  = 4'd3;
    localparam logic [3:0] PS_X0B  = 4'd4;
    localparam logic [3:0] PS_X1   = 4'd5;
    localparam logic [3:0] PS_AP00 = 4'd6;
    localparam logic [3:0] PS_AP01 = 4'd7;
    localparam logic [3:0] PS_Q00  = 4'd8;
    localparam logic [3:0] PS_Q01  = 4'd9;
    localparam logic [3:0] PS_Q11  = 4'd10;
    localparam logic [3:0] PS_P00  = 4'd11;
    localparam logic [3:0] PS_P10  = 4'd12;

    // update program
    localparam logic [3:0] US_X0  = 4'd0;
    localparam logic [3:0] US_X1  = 4'd1;
    localparam logic [3:0] US_P10 = 4'd2;
    localparam logic [3:0] US_P11 = 4'd3;
    localparam logic [3:0] US_P00 = 4'd4;
    localparam logic [3:0] US_P01 = 4'd5;

    typedef logic signed [63:0]       acc_t;
    typedef logic signed [MUL_W-1:0]  mul_t;
    typedef logic signed [PROD_W-1:0] prod_t;

    typedef struct packed {
        logic               opcode;
        logic signed [31:0] accel;
        logic [15:0]        time_step;
        logic signed [31:0] measured_altitude;
    } in_beat_t;

    typedef struct packed {
        logic signed [31:0] altitude_estimate;
        logic signed [31:0] velocity_estimate;
        logic               saturated;
    } out_beat_t;

    typedef struct packed {
        logic               clamp;
        logic signed [31:0] val;
    } sat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PRED_MUL,
        ST_PRED_WB,
        ST_UPD_INIT,
        ST_DIV_RUN,
        ST_DIV_END,
        ST_UPD_MUL,
        ST_UPD_WB,
        ST_DONE
    } state_t;

    function automatic sat_t sat32(input acc_t v);
        sat_t r;
        if (v > acc_t'(INT32_MAX)) begin
            r.clamp = 1'b1;
            r.val   = INT32_MAX;
        end else if (v < acc_t'(INT32_MIN)) begin
            r.clamp = 1'b1;
            r.val   = INT32_MIN;
        end else begin
            r.clamp = 1'b0;
            r.val   = v[31:0];
        end
        return r;
    endfunction

endpackage

@@ rtl/core/two_state_kalman_filter.sv @@
// Channel   Dir  Handshake           Payload
// s_        in   s_valid / s_ready   in_beat_t  (opcode, accel, time_step, measured_altitude)
// m_        out  m_valid / m_ready   out_beat_t (altitude_estimate, velocity_estimate, saturated)
// APB       in   psel/penable/pwrite 2 x 31-bit registers at 0x0, 0x4
//
// One shared 33x33 multiplier and a 1-bit/cycle restoring divider.
// Predict: 13 products.
// Update: two gains from the divider, then 6 products.
// An update with P00 + R <= 0 skips the division and products, keeps x and P, and flags saturated.
// s_ready is high only when idle; a finished beat waits in the output register.
// Reset (aresetn low, synchronous) restores x = 0, P = I and the register defaults.
module two_state_kalman_filter (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  tskf_pkg::in_beat_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output tskf_pkg::out_beat_t  m_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import tskf_pkg::*;

    state_t state_reg, state_next;

    logic [30:0] q_var_reg, r_var_reg;

    logic signed [31:0] x0_reg, x1_reg;
    logic signed [31:0] p00_reg, p01_reg, p10_reg, p11_reg;

    logic [FRAC_BITS-1:0] dt_reg;
    logic [FRAC_BITS:0]   dt2_reg, dt3_reg, dt4_reg;
    logic signed [31:0]   a_reg, z_reg;
    acc_t                 acc_reg, ap00_reg, ap01_reg, q00_reg, q01_reg, q11_reg;
    logic signed [31:0]   y_reg, k0_reg, k1_reg;
    logic                 sat_reg;
    logic [3:0]           step_reg;

    logic [NUM_W-1:0]     div_q_reg;
    logic [32:0]          div_rem_reg, div_den_reg;
    logic                 div_neg_reg, div_sel_reg;
    logic [CNT_W-1:0]     div_cnt_reg;

    prod_t prod_reg;
    mul_t  op_a, op_b;

    logic      m_valid_reg;
    out_beat_t m_data_reg;

    logic out_free;
    logic accept;
    logic cfg_wr;

    // rounding of the last product
    localparam prod_t RND_HALF = prod_t'(66'd1 << (FRAC_BITS - 1));
    prod_t rnd_sh;
    acc_t  rnd;
    assign rnd_sh = (prod_reg + RND_HALF) >>> FRAC_BITS;
    assign rnd    = signed'(rnd_sh[63:0]);

    // update front end
    acc_t s_sum;
    sat_t y_sat;
    assign s_sum = acc_t'(p00_reg) + acc_t'({1'b0, r_var_reg});
    assign y_sat = sat32(acc_t'(z_reg) - acc_t'(x0_reg));

    // divider step
    logic [33:0] div_trial;
    logic        div_ge;
    assign div_trial = {div_rem_reg, div_q_reg[NUM_W-1]};
    assign div_ge    = div_trial >= {1'b0, div_den_reg};

    acc_t div_pos, div_val;
    sat_t k_sat;
    assign div_pos = acc_t'(div_q_reg);
    assign div_val = div_neg_reg ? -div_pos : div_pos;
    assign k_sat   = sat32(div_val);

    logic [31:0] p10_mag, p00_mag;
    assign p00_mag = p00_reg[31] ? 32'(-p00_reg) : 32'(p00_reg);
    assign p10_mag = p10_reg[31] ? 32'(-p10_reg) : 32'(p10_reg);

    // writeback sums
    sat_t w_x0b, w_x1p, w_p00p, w_p10p, w_p01p, w_p11p;
    sat_t w_x0u, w_x1u, w_p00u, w_p01u, w_p10u, w_p11u;
    assign w_x0b  = sat32(acc_reg + rnd);
    assign w_x1p  = sat32(acc_t'(x1_reg) + rnd);
    assign w_p00p = sat32(ap00_reg + rnd + q00_reg);
    assign w_p10p = sat32(acc_t'(p10_reg) + rnd + q01_reg);
    assign w_p01p = sat32(ap01_reg + q01_reg);
    assign w_p11p = sat32(acc_t'(p11_reg) + q11_reg);
    assign w_x0u  = sat32(acc_t'(x0_reg) + rnd);
    assign w_x1u  = sat32(acc_t'(x1_reg) + rnd);
    assign w_p00u = sat32(acc_t'(p00_reg) - rnd);
    assign w_p01u = sat32(acc_t'(p01_reg) - rnd);
    assign w_p10u = sat32(acc_t'(p10_reg) - rnd);
    assign w_p11u = sat32(acc_t'(p11_reg) - rnd);

    assign out_free = !m_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;
    assign cfg_wr   = psel && penable && pwrite && pready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = (s_data.opcode == OP_PREDICT) ? ST_PRED_MUL : ST_UPD_INIT;
                end
            end
            ST_PRED_MUL: state_next = ST_PRED_WB;
            ST_PRED_WB:  state_next = (step_reg == PS_P10) ? ST_DONE : ST_PRED_MUL;
            ST_UPD_INIT: state_next = (s_sum <= 0) ? ST_DONE : ST_DIV_RUN;
            ST_DIV_RUN: begin
                if (div_cnt_reg == CNT_W'(NUM_W - 1)) begin
                    state_next = ST_DIV_END;
                end
            end
            ST_DIV_END:  state_next = div_sel_reg ? ST_UPD_MUL : ST_DIV_RUN;
            ST_UPD_MUL:  state_next = ST_UPD_WB;
            ST_UPD_WB:   state_next = (step_reg == US_P01) ? ST_DONE : ST_UPD_MUL;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control outputs: handshake and multiplier operand select
    always_comb begin
        s_ready = 1'b0;
        op_a    = '0;
        op_b    = '0;
        unique case (state_reg)
            ST_IDLE: s_ready = 1'b1;
            ST_PRED_MUL: begin
                case (step_reg)
                    PS_DT2:  begin op_a = mul_t'(dt_reg);  op_b = mul_t'(dt_reg); end
                    PS_DT3:  begin op_a = mul_t'(dt2_reg); op_b = mul_t'(dt_reg); end
                    PS_DT4:  begin op_a = mul_t'(dt3_reg); op_b = mul_t'(dt_reg); end
                    PS_X0A:  begin op_a = mul_t'(dt_reg);  op_b = mul_t'(x1_reg); end
                    PS_X0B:  begin op_a = mul_t'(dt2_reg[FRAC_BITS:1]); op_b = mul_t'(a_reg); end
                    PS_X1:   begin op_a = mul_t'(dt_reg);  op_b = mul_t'(a_reg); end
                    PS_AP00: begin op_a = mul_t'(dt_reg);  op_b = mul_t'(p10_reg); end
                    PS_AP01: begin op_a = mul_t'(dt_reg);  op_b = mul_t'(p11_reg); end
                    PS_Q00:  begin op_a = mul_t'(q_var_reg); op_b = mul_t'(dt4_reg[FRAC_BITS:2]); end
                    PS_Q01:  begin op_a = mul_t'(q_var_reg); op_b = mul_t'(dt3_reg[FRAC_BITS:1]); end
                    PS_Q11:  begin op_a = mul_t'(q_var_reg); op_b = mul_t'(dt2_reg); end
                    PS_P00:  begin op_a = mul_t'(dt_reg);  op_b = signed'(ap01_reg[MUL_W-1:0]); end
                    PS_P10:  begin op_a = mul_t'(dt_reg);  op_b = mul_t'(p11_reg); end
                    default: begin op_a = '0; op_b = '0; end
                endcase
            end
            ST_UPD_MUL: begin
                case (step_reg)
                    US_X0:   begin op_a = mul_t'(k0_reg); op_b = mul_t'(y_reg); end
                    US_X1:   begin op_a = mul_t'(k1_reg); op_b = mul_t'(y_reg); end
                    US_P10:  begin op_a = mul_t'(k1_reg); op_b = mul_t'(p00_reg); end
                    US_P11:  begin op_a = mul_t'(k1_reg); op_b = mul_t'(p01_reg); end
                    US_P00:  begin op_a = mul_t'(k0_reg); op_b = mul_t'(p00_reg); end
                    US_P01:  begin op_a = mul_t'(k0_reg); op_b = mul_t'(p01_reg); end
                    default: begin op_a = '0; op_b = '0; end
                endcase
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_var_reg <= Q_RESET;
            r_var_reg <= R_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_ACCEL_NOISE) begin
                q_var_reg <= pwdata[30:0];
            end else begin
                r_var_reg <= pwdata[30:0];
            end
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MEAS_VAR) ? {1'b0, r_var_reg} : {1'b0, q_var_reg};

    // filter state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x0_reg  <= '0;
            x1_reg  <= '0;
            p00_reg <= 32'(64'd1 << FRAC_BITS);
            p01_reg <= '0;
            p10_reg <= '0;
            p11_reg <= 32'(64'd1 << FRAC_BITS);
            sat_reg <= 1'b0;
        end else begin
            if (accept) begin
                sat_reg <= 1'b0;
            end
            if (state_reg == ST_PRED_WB) begin
                case (step_reg)
                    PS_X0B: begin x0_reg <= w_x0b.val; sat_reg <= sat_reg | w_x0b.clamp; end
                    PS_X1:  begin x1_reg <= w_x1p.val; sat_reg <= sat_reg | w_x1p.clamp; end
                    PS_P00: begin p00_reg <= w_p00p.val; sat_reg <= sat_reg | w_p00p.clamp; end
                    PS_P10: begin
                        p10_reg <= w_p10p.val;
                        p01_reg <= w_p01p.val;
                        p11_reg <= w_p11p.val;
                        sat_reg <= sat_reg | w_p10p.clamp | w_p01p.clamp | w_p11p.clamp;
                    end
                    default: ;
                endcase
            end
            if (state_reg == ST_UPD_INIT) begin
                sat_reg <= sat_reg | (s_sum <= 0) | ((s_sum > 0) && y_sat.clamp);
            end
            if (state_reg == ST_DIV_END) begin
                sat_reg <= sat_reg | k_sat.clamp;
            end
            if (state_reg == ST_UPD_WB) begin
                case (step_reg)
                    US_X0:  begin x0_reg <= w_x0u.val;   sat_reg <= sat_reg | w_x0u.clamp; end
                    US_X1:  begin x1_reg <= w_x1u.val;   sat_reg <= sat_reg | w_x1u.clamp; end
                    US_P10: begin p10_reg <= w_p10u.val; sat_reg <= sat_reg | w_p10u.clamp; end
                    US_P11: begin p11_reg <= w_p11u.val; sat_reg <= sat_reg | w_p11u.clamp; end
                    US_P00: begin p00_reg <= w_p00u.val; sat_reg <= sat_reg | w_p00u.clamp; end
                    US_P01: begin p01_reg <= w_p01u.val; sat_reg <= sat_reg | w_p01u.clamp; end
                    default: ;
                endcase
            end
        end
    end

    // sequencer and working registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= '0;
            div_cnt_reg <= '0;
            div_sel_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    step_reg <= '0;
                end
                ST_PRED_WB, ST_UPD_WB: begin
                    step_reg <= step_reg + 4'd1;
                end
                ST_UPD_INIT: begin
                    div_cnt_reg <= '0;
                    div_sel_reg <= 1'b0;
                end
                ST_DIV_RUN: begin
                    div_cnt_reg <= div_cnt_reg + CNT_W'(1);
                end
                ST_DIV_END: begin
                    div_cnt_reg <= '0;
                    div_sel_reg <= 1'b1;
                    step_reg    <= '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
        if (accept) begin
            // dt converted to FRAC_BITS fraction bits with truncation
            dt_reg <= FRAC_BITS'({s_data.time_step, {FRAC_BITS{1'b0}}} >> 16);
            a_reg  <= s_data.accel;
            z_reg  <= s_data.measured_altitude;
        end
        if (state_reg == ST_PRED_WB) begin
            case (step_reg)
                PS_DT2:  dt2_reg  <= rnd[FRAC_BITS:0];
                PS_DT3:  dt3_reg  <= rnd[FRAC_BITS:0];
                PS_DT4:  dt4_reg  <= rnd[FRAC_BITS:0];
                PS_X0A:  acc_reg  <= acc_t'(x0_reg) + rnd;
                PS_AP00: ap00_reg <= acc_t'(p00_reg) + rnd;
                PS_AP01: ap01_reg <= acc_t'(p01_reg) + rnd;
                PS_Q00:  q00_reg  <= rnd;
                PS_Q01:  q01_reg  <= rnd;
                PS_Q11:  q11_reg  <= rnd;
                default: ;
            endcase
        end
        if (state_reg == ST_UPD_INIT) begin
            y_reg       <= y_sat.val;
            div_den_reg <= s_sum[32:0];
            div_neg_reg <= p00_reg[31];
            div_q_reg   <= {p00_mag, {FRAC_BITS{1'b0}}};
            div_rem_reg <= '0;
        end
        if (state_reg == ST_DIV_RUN) begin
            div_rem_reg <= div_ge ? 33'(div_trial - {1'b0, div_den_reg}) : div_trial[32:0];
            div_q_reg   <= {div_q_reg[NUM_W-2:0], div_ge};
        end
        if (state_reg == ST_DIV_END) begin
            if (!div_sel_reg) begin
                k0_reg      <= k_sat.val;
                div_neg_reg <= p10_reg[31];
                div_q_reg   <= {p10_mag, {FRAC_BITS{1'b0}}};
                div_rem_reg <= '0;
            end else begin
                k1_reg <= k_sat.val;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DONE && out_free) begin
            m_data_reg.altitude_estimate <= x0_reg;
            m_data_reg.velocity_estimate <= x1_reg;
            m_data_reg.saturated         <= sat_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ rtl/core/tskf_sva.sv @@
module tskf_sva (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input tskf_pkg::out_beat_t m_data
);
    import tskf_pkg::*;

    // no result appears right after reset
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    // an accepted beat keeps the block busy, with s_ready low after acceptance
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready ##1 !s_ready)
        else $error("s_ready returned too early");

    // a result is never produced in the cycle after input acceptance
    a_no_instant: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !m_valid) |=> !m_valid)
        else $error("result appeared without computation");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("stalled result changed");

endmodule

bind two_state_kalman_filter tskf_sva u_tskf_sva (.*);

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import tskf_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_beat_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_beat_t   m_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    two_state_kalman_filter dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // filter state mirror
    logic signed [31:0] est_pos, est_vel;
    logic signed [31:0] cov [4];
    longint             q_var, r_var;

    in_beat_t  pending_beats [$];
    out_beat_t expected_states [$];
    bit        no_idle = 1'b0;
    bit        hold_go = 1'b0;
    int        hold_cnt = 0;
    int        errors = 0;
    int        n_pred = 0, n_upd = 0, n_sat = 0, n_checked = 0;

    function automatic longint mul_round(longint a, longint b);
        return (a * b + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    endfunction

    function automatic logic signed [31:0] clamp32(longint v, inout bit flag);
        if (v > 64'sd2147483647) begin
            flag = 1'b1;
            return INT32_MAX;
        end
        if (v < -64'sd2147483648) begin
            flag = 1'b1;
            return INT32_MIN;
        end
        return v[31:0];
    endfunction

    task automatic step_filter(input in_beat_t b, output out_beat_t r);
        bit     sat;
        longint dt, dt2, dt3, dt4, a, x0, x1, p00, p01, p10, p11;
        longint ap00, ap01, q00, q01, q11, s, y, k0, k1;
        sat = 1'b0;
        x0 = est_pos; x1 = est_vel;
        p00 = cov[0]; p01 = cov[1]; p10 = cov[2]; p11 = cov[3];
        if (b.opcode == OP_PREDICT) begin
            dt = longint'(b.time_step);
            a = longint'(b.accel);
            dt2 = mul_round(dt, dt);
            dt3 = mul_round(dt2, dt);
            dt4 = mul_round(dt3, dt);
            est_pos = clamp32(x0 + mul_round(dt, x1) + mul_round(dt2 >>> 1, a), sat);
            est_vel = clamp32(x1 + mul_round(dt, a), sat);
            ap00 = p00 + mul_round(dt, p10);
            ap01 = p01 + mul_round(dt, p11);
            q00 = mul_round(q_var, dt4 >>> 2);
            q01 = mul_round(q_var, dt3 >>> 1);
            q11 = mul_round(q_var, dt2);
            cov[0] = clamp32(ap00 + mul_round(dt, ap01) + q00, sat);
            cov[1] = clamp32(ap01 + q01, sat);
            cov[2] = clamp32(p10 + mul_round(dt, p11) + q01, sat);
            cov[3] = clamp32(p11 + q11, sat);
        end else begin
            s = p00 + r_var;
            if (s <= 0) begin
                sat = 1'b1;
            end else begin
                y = clamp32(longint'(b.measured_altitude) - x0, sat);
                k0 = clamp32((p00 <<< FRAC_BITS) / s, sat);
                k1 = clamp32((p10 <<< FRAC_BITS) / s, sat);
                est_pos = clamp32(x0 + mul_round(k0, y), sat);
                est_vel = clamp32(x1 + mul_round(k1, y), sat);
                cov[0] = clamp32(p00 - mul_round(k0, p00), sat);
                cov[1] = clamp32(p01 - mul_round(k0, p01), sat);
                cov[2] = clamp32(p10 - mul_round(k1, p00), sat);
                cov[3] = clamp32(p11 - mul_round(k1, p01), sat);
            end
        end
        r.altitude_estimate = est_pos;
        r.velocity_estimate = est_vel;
        r.saturated = sat;
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (pending_beats.size() > 0 && (no_idle || $urandom_range(99) >= 23)) begin
                s_valid <= 1'b1;
                s_data <= pending_beats.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // expected result on accept
    always @(posedge aclk) begin
        out_beat_t r;
        if (aresetn && s_valid && s_ready) begin
            step_filter(s_data, r);
            if (s_data.opcode == OP_PREDICT) n_pred++;
            else n_upd++;
            expected_states.push_back(r);
        end
    end

    // receiver, with one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_go && hold_cnt < 400) begin
            hold_cnt <= hold_cnt + 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= no_idle || $urandom_range(99) >= 23;
        end
    end

    // monitor
    always @(posedge aclk) begin
        out_beat_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_states.size() == 0) begin
                $error("result beat with nothing expected");
                errors++;
            end else begin
                e = expected_states.pop_front();
                n_checked++;
                if (m_data.saturated) n_sat++;
                if (m_data.altitude_estimate !== e.altitude_estimate) begin
                    $error("altitude_estimate exp %0d got %0d",
                           e.altitude_estimate, m_data.altitude_estimate);
                    errors++;
                end
                if (m_data.velocity_estimate !== e.velocity_estimate) begin
                    $error("velocity_estimate exp %0d got %0d",
                           e.velocity_estimate, m_data.velocity_estimate);
                    errors++;
                end
                if (m_data.saturated !== e.saturated) begin
                    $error("saturated exp %0d got %0d", e.saturated, m_data.saturated);
                    errors++;
                end
            end
        end
    end

    task automatic reg_write(input logic idx, input logic [31:0] val);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_ACCEL_NOISE) q_var = longint'(val[30:0]);
        else r_var = longint'(val[30:0]);
    endtask

    task automatic wait_drained();
        while (pending_beats.size() > 0 || s_valid || expected_states.size() > 0)
            @(posedge aclk);
        repeat (150) @(posedge aclk);
    endtask

    function automatic in_beat_t mk_beat(logic op, logic signed [31:0] acc,
                                         logic [15:0] dt, logic signed [31:0] z);
        in_beat_t b;
        b.opcode = op;
        b.accel = acc;
        b.time_step = dt;
        b.measured_altitude = z;
        return b;
    endfunction

    function automatic in_beat_t rand_beat();
        in_beat_t b;
        b = mk_beat($urandom_range(99) < 55 ? OP_PREDICT : OP_UPDATE,
                    $urandom, 16'($urandom), $urandom);
        if ($urandom_range(99) >= 15) begin
            // plausible flight: small dt, a few g, altitude within a km
            b.time_step = 16'($urandom_range(6554));
            b.accel = $signed($urandom_range(40 << 16)) - (20 << 16);
            b.measured_altitude = $signed($urandom_range(2000 << 16)) - (1000 << 16);
        end
        return b;
    endfunction

    task automatic run_random(input int count);
        repeat (count) pending_beats.push_back(rand_beat());
        wait_drained();
    endtask

    initial begin
        est_pos = 0;
        est_vel = 0;
        cov[0] = 32'sd1 <<< FRAC_BITS; cov[1] = 0; cov[2] = 0; cov[3] = 32'sd1 <<< FRAC_BITS;
        q_var = longint'(Q_RESET);
        r_var = longint'(R_RESET);
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reset registers, field extremes, clamps
        pending_beats.push_back(mk_beat(OP_PREDICT, 32'sd0, 16'd0, INT32_MAX));
        pending_beats.push_back(mk_beat(OP_PREDICT, 32'sd1 <<< 16, 16'd6554, 32'sd0));
        pending_beats.push_back(mk_beat(OP_UPDATE, INT32_MIN, 16'hFFFF, 32'sd5 <<< 16));
        pending_beats.push_back(mk_beat(OP_UPDATE, INT32_MAX, 16'd0, INT32_MAX));
        pending_beats.push_back(mk_beat(OP_UPDATE, 32'sd0, 16'd0, INT32_MIN));
        pending_beats.push_back(mk_beat(OP_PREDICT, INT32_MAX, 16'hFFFF, INT32_MIN));
        pending_beats.push_back(mk_beat(OP_PREDICT, INT32_MAX, 16'hFFFF, 32'sd0));
        pending_beats.push_back(mk_beat(OP_PREDICT, INT32_MIN, 16'hFFFF, 32'sd0));
        pending_beats.push_back(mk_beat(OP_UPDATE, 32'sd0, 16'd0, 32'sd0));
        pending_beats.push_back(mk_beat(OP_PREDICT, INT32_MIN, 16'h8000, -32'sd1));
        pending_beats.push_back(mk_beat(OP_UPDATE, -32'sd1, 16'h1, -32'sd1));
        wait_drained();

        reg_write(REG_ACCEL_NOISE, 32'h7FFF_FFFF);
        reg_write(REG_MEAS_VAR, 32'h0000_0001);
        repeat (4) pending_beats.push_back(mk_beat(OP_PREDICT, 32'sd0, 16'hFFFF, 32'sd0));
        pending_beats.push_back(mk_beat(OP_UPDATE, 32'sd0, 16'd0, INT32_MAX));
        pending_beats.push_back(mk_beat(OP_UPDATE, 32'sd0, 16'd0, INT32_MIN));
        wait_drained();

        reg_write(REG_ACCEL_NOISE, 32'h0);
        reg_write(REG_MEAS_VAR, 32'hFFFF_FFFF);
        hold_go = 1'b1;
        run_random(200);

        reg_write(REG_ACCEL_NOISE, 32'h0000_8000);
        reg_write(REG_MEAS_VAR, 32'h0000_28F6);
        no_idle = 1'b1;
        run_random(200);
        no_idle = 1'b0;

        reg_write(REG_ACCEL_NOISE, $urandom);
        reg_write(REG_MEAS_VAR, $urandom_range(32'h7FFF_FFFF, 1));
        run_random(250);

        reg_write(REG_ACCEL_NOISE, $urandom_range(32'h0004_0000));
        reg_write(REG_MEAS_VAR, $urandom_range(32'h0001_0000, 1));
        run_random(280);

        $display("%0d predict and %0d update beats, %0d results checked, %0d saturated",
                 n_pred, n_upd, n_checked, n_sat);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #8ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule

@@ two_state_kalman_filter.f @@
rtl/core/tskf_pkg.sv
rtl/core/two_state_kalman_filter.sv
rtl/core/tskf_sva.sv
sim/tb_top.sv
